@@ rtl/core/matrix_add_sub_multiply_macros.svh @@
// Assertion helpers shared by the block's RTL files.
// Each helper expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef MATRIX_ADD_SUB_MULTIPLY_MACROS_SVH
`define MATRIX_ADD_SUB_MULTIPLY_MACROS_SVH

// The consequence must hold in the same cycle as the antecedent.
`define MAS_CHECK_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mas same-cycle check failed");

// The consequence must hold in the cycle after the antecedent.
`define MAS_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mas next-cycle check failed");

`endif

@@ rtl/core/mas_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mas_pkg;

	// Sizing of the element stores and the arithmetic.
	localparam int MAX_DIM     = 8;
	localparam int VALUE_WIDTH = 32;
	localparam int ELEM_W      = 32;
	localparam int POS_W       = 3;
	localparam int DIM_W       = 4;
	localparam int OP_W        = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int DEPTH       = MAX_DIM * MAX_DIM;
	localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FRAC_BITS   = 16;
	localparam int SAT_BITS    = (VALUE_WIDTH < ELEM_W) ? VALUE_WIDTH : ELEM_W;
	localparam int SUM_W       = ELEM_W + 1;
	localparam int PROD_W      = 2 * ELEM_W;
	localparam int ACC_W       = PROD_W + $clog2(MAX_DIM) + 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
	localparam logic [OP_W-1:0] OP_SUB  = 2'd1;
	localparam logic [OP_W-1:0] OP_MUL  = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_A_COLS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_ROWS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [DIM_W-1:0] a_rows;
		logic [DIM_W-1:0] a_cols;
		logic [DIM_W-1:0] b_rows;
		logic [DIM_W-1:0] b_cols;
	} mas_cfg_t;

	// Controller to datapath.
	typedef struct packed {
		logic             issue;
		logic             first;
		logic             k_last;
		logic             elem_last;
		logic             is_mul;
		logic             is_sub;
		logic             err_push;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] kidx;
	} mas_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_free;
		logic written;
	} mas_status_t;

	// Control that travels with the datapath stages.
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             k_last;
		logic             elem_last;
		logic             is_mul;
		logic             is_sub;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} mas_pipe_t;

	// Only the low DIM_W bits of a dimension are used; zero there is held as one, anything above MAX_DIM as MAX_DIM.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
		logic [DIM_W-1:0] low;
		low = v[DIM_W-1:0];
		if (low == '0) begin
			return DIM_W'(1);
		end else if (int'(low) > MAX_DIM) begin
			return DIM_W'(MAX_DIM);
		end
		return low;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/mas_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Load channel: one element written into store A or B.
interface mas_load_if;
	logic                             valid;
	logic                             ready;
	logic                             target;
	logic [mas_pkg::POS_W-1:0]        row_index;
	logic [mas_pkg::POS_W-1:0]        col_index;
	logic signed [mas_pkg::ELEM_W-1:0] element;
	logic                             final_load;

	modport source (output valid, target, row_index, col_index, element, final_load,
		input ready);
	modport sink (input valid, target, row_index, col_index, element, final_load,
		output ready);
endinterface

// Result channel: one element of the result matrix.
interface mas_result_if;
	logic                             valid;
	logic                             ready;
	logic [mas_pkg::POS_W-1:0]        out_row;
	logic [mas_pkg::POS_W-1:0]        out_col;
	logic signed [mas_pkg::ELEM_W-1:0] out_value;
	logic                             is_last;
	logic                             dim_error;

	modport source (output valid, out_row, out_col, out_value, is_last, dim_error,
		input ready);
	modport sink (input valid, out_row, out_col, out_value, is_last, dim_error,
		output ready);
endinterface

// Configuration write channel.
interface mas_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mas_pkg::CFG_IDX_W-1:0]   index;
	logic [mas_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mas_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_add_sub_multiply_macros.svh"

module mas_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               load_wr,
	input  wire logic                               load_target,
	input  wire logic [mas_pkg::POS_W-1:0]          load_row,
	input  wire logic [mas_pkg::POS_W-1:0]          load_col,
	input  wire logic signed [mas_pkg::ELEM_W-1:0]  load_element,
	input  wire mas_pkg::mas_cmd_t                  cmd,
	output mas_pkg::mas_status_t                    status,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [mas_pkg::POS_W-1:0]               out_row,
	output logic [mas_pkg::POS_W-1:0]               out_col,
	output logic signed [mas_pkg::ELEM_W-1:0]       out_value,
	output logic                                    out_last,
	output logic                                    out_err
);

	localparam int ACC_W  = mas_pkg::ACC_W;
	localparam int ELEM_W = mas_pkg::ELEM_W;
	localparam int ADDR_W = mas_pkg::ADDR_W;
	localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(1) << (mas_pkg::FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX =
		signed'({{(ACC_W - mas_pkg::SAT_BITS + 1){1'b0}}, {(mas_pkg::SAT_BITS - 1){1'b1}}});
	localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

	logic signed [ELEM_W-1:0] mem_a [mas_pkg::DEPTH];
	logic signed [ELEM_W-1:0] mem_b [mas_pkg::DEPTH];

	logic              wr_ok;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;

	logic signed [ELEM_W-1:0]          rd_a_s1;
	logic signed [ELEM_W-1:0]          rd_b_s1;
	logic signed [mas_pkg::PROD_W-1:0] prod_s2;
	logic signed [mas_pkg::SUM_W-1:0]  sum_s2;
	logic signed [ACC_W-1:0]           addend;
	logic signed [ACC_W-1:0]           acc_s3;
	logic signed [ACC_W-1:0]           rnd_s4;
	logic signed [ACC_W-1:0]           shifted;
	logic signed [ACC_W-1:0]           clamped;

	mas_pkg::mas_pipe_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;

	logic                     load_out;
	logic                     out_valid_q;
	logic [mas_pkg::POS_W-1:0] out_row_q;
	logic [mas_pkg::POS_W-1:0] out_col_q;
	logic signed [ELEM_W-1:0] out_value_q;
	logic                     out_last_q;
	logic                     out_err_q;

	// Element stores, written by loads and read once a cycle for the walk.
	assign wr_ok = load_wr && (int'(load_row) < mas_pkg::MAX_DIM)
		&& (int'(load_col) < mas_pkg::MAX_DIM);
	assign wr_addr = ADDR_W'(load_row * mas_pkg::MAX_DIM + load_col);

	// Multiply walks row i of A against column j of B; add and subtract
	// read the same position in both stores.
	assign rd_addr_a = cmd.is_mul ? ADDR_W'(cmd.row * mas_pkg::MAX_DIM + cmd.kidx)
		: ADDR_W'(cmd.row * mas_pkg::MAX_DIM + cmd.col);
	assign rd_addr_b = cmd.is_mul ? ADDR_W'(cmd.kidx * mas_pkg::MAX_DIM + cmd.col)
		: ADDR_W'(cmd.row * mas_pkg::MAX_DIM + cmd.col);

	always_ff @(posedge clk) begin
		if (wr_ok && !load_target) begin
			mem_a[wr_addr] <= load_element;
		end
		if (wr_ok && load_target) begin
			mem_b[wr_addr] <= load_element;
		end
		rd_a_s1 <= mem_a[rd_addr_a];
		rd_b_s1 <= mem_b[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1.valid     <= cmd.issue;
			ctl_s1.first     <= cmd.first;
			ctl_s1.k_last    <= cmd.k_last;
			ctl_s1.elem_last <= cmd.elem_last;
			ctl_s1.is_mul    <= cmd.is_mul;
			ctl_s1.is_sub    <= cmd.is_sub;
			ctl_s1.row       <= cmd.row;
			ctl_s1.col       <= cmd.col;
			ctl_s2           <= ctl_s1;
			ctl_s3           <= ctl_s2;
			ctl_s4.valid     <= ctl_s3.valid && ctl_s3.k_last;
			ctl_s4.first     <= ctl_s3.first;
			ctl_s4.k_last    <= ctl_s3.k_last;
			ctl_s4.elem_last <= ctl_s3.elem_last;
			ctl_s4.is_mul    <= ctl_s3.is_mul;
			ctl_s4.is_sub    <= ctl_s3.is_sub;
			ctl_s4.row       <= ctl_s3.row;
			ctl_s4.col       <= ctl_s3.col;
		end
	end

	// Sums are scaled up by the fraction width so that the shared rounding
	// step hands them back unchanged.
	assign addend = ctl_s2.is_mul ? ACC_W'(prod_s2) : (ACC_W'(sum_s2) <<< mas_pkg::FRAC_BITS);

	always_ff @(posedge clk) begin
		prod_s2 <= rd_a_s1 * rd_b_s1;
		if (ctl_s1.is_sub) begin
			sum_s2 <= mas_pkg::SUM_W'(rd_a_s1) - mas_pkg::SUM_W'(rd_b_s1);
		end else begin
			sum_s2 <= mas_pkg::SUM_W'(rd_a_s1) + mas_pkg::SUM_W'(rd_b_s1);
		end
		if (ctl_s2.valid) begin
			acc_s3 <= ctl_s2.first ? addend : acc_s3 + addend;
		end
		if (ctl_s3.valid && ctl_s3.k_last) begin
			rnd_s4 <= acc_s3 + ROUND;
		end
	end

	assign shifted = rnd_s4 >>> mas_pkg::FRAC_BITS;

	always_comb begin
		if (shifted > SAT_MAX) begin
			clamped = SAT_MAX;
		end else if (shifted < SAT_MIN) begin
			clamped = SAT_MIN;
		end else begin
			clamped = shifted;
		end
	end

	// Output register: one result waits here until it is taken.
	assign load_out = ctl_s4.valid || cmd.err_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.err_push) begin
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_value_q <= '0;
			out_last_q  <= 1'b1;
			out_err_q   <= 1'b1;
		end else if (ctl_s4.valid) begin
			out_row_q   <= ctl_s4.row;
			out_col_q   <= ctl_s4.col;
			out_value_q <= clamped[ELEM_W-1:0];
			out_last_q  <= ctl_s4.elem_last;
			out_err_q   <= 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign status.written  = load_out;

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;
	assign out_err   = out_err_q;

	`MAS_CHECK_NOW(a_no_overwrite, load_out, (!out_valid_q || out_ready))
	`MAS_CHECK_NOW(a_err_item_shape, (out_valid_q && out_err_q), (out_last_q && out_value_q == '0))

endmodule

`default_nettype wire

@@ rtl/core/mas_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_add_sub_multiply_macros.svh"

module mas_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mas_pkg::mas_cfg_t     cfg,
	input  wire logic                  load_accept,
	input  wire logic                  load_final,
	output logic                       load_ready,
	input  wire mas_pkg::mas_status_t  status,
	output mas_pkg::mas_cmd_t          cmd
);

	localparam int DIM_W = mas_pkg::DIM_W;
	localparam int POS_W = mas_pkg::POS_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_ISSUE = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_ERR   = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [POS_W-1:0] i_q, i_d;
	logic [POS_W-1:0] j_q, j_d;
	logic [POS_W-1:0] k_q, k_d;
	logic [DIM_W-1:0] rows_q, rows_d;
	logic [DIM_W-1:0] cols_q, cols_d;
	logic [DIM_W-1:0] kmax_q, kmax_d;
	logic             is_mul_q, is_mul_d;
	logic             is_sub_q, is_sub_d;

	logic start_run;
	logic mismatch;
	logic last_i, last_j, last_k;

	assign start_run = load_accept && load_final && (cfg.operation != mas_pkg::OP_NONE);
	assign mismatch  = (cfg.operation == mas_pkg::OP_MUL) ? (cfg.a_cols != cfg.b_rows)
		: ((cfg.a_rows != cfg.b_rows) || (cfg.a_cols != cfg.b_cols));

	assign last_i = (DIM_W'(i_q) == rows_q - DIM_W'(1));
	assign last_j = (DIM_W'(j_q) == cols_q - DIM_W'(1));
	assign last_k = (DIM_W'(k_q) == kmax_q - DIM_W'(1));

	assign load_ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		j_d      = j_q;
		k_d      = k_q;
		rows_d   = rows_q;
		cols_d   = cols_q;
		kmax_d   = kmax_q;
		is_mul_d = is_mul_q;
		is_sub_d = is_sub_q;

		cmd           = '0;
		cmd.first     = (k_q == '0);
		cmd.k_last    = last_k;
		cmd.elem_last = last_i && last_j;
		cmd.is_mul    = is_mul_q;
		cmd.is_sub    = is_sub_q;
		cmd.row       = i_q;
		cmd.col       = j_q;
		cmd.kidx      = k_q;

		case (state_q)
			S_IDLE: begin
				if (start_run) begin
					is_mul_d = (cfg.operation == mas_pkg::OP_MUL);
					is_sub_d = (cfg.operation == mas_pkg::OP_SUB);
					rows_d   = cfg.a_rows;
					cols_d   = (cfg.operation == mas_pkg::OP_MUL) ? cfg.b_cols : cfg.a_cols;
					kmax_d   = (cfg.operation == mas_pkg::OP_MUL) ? cfg.a_cols : DIM_W'(1);
					i_d      = '0;
					j_d      = '0;
					k_d      = '0;
					state_d  = mismatch ? S_ERR : S_START;
				end
			end
			S_START: begin
				if (status.out_free) begin
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				cmd.issue = 1'b1;
				if (last_k) begin
					k_d     = '0;
					state_d = S_DRAIN;
				end else begin
					k_d = k_q + POS_W'(1);
				end
			end
			S_DRAIN: begin
				if (status.written) begin
					if (last_i && last_j) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_START;
						if (last_j) begin
							j_d = '0;
							i_d = i_q + POS_W'(1);
						end else begin
							j_d = j_q + POS_W'(1);
						end
					end
				end
			end
			S_ERR: begin
				if (status.out_free) begin
					cmd.err_push = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			rows_q   <= DIM_W'(1);
			cols_q   <= DIM_W'(1);
			kmax_q   <= DIM_W'(1);
			is_mul_q <= 1'b0;
			is_sub_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			i_q      <= i_d;
			j_q      <= j_d;
			k_q      <= k_d;
			rows_q   <= rows_d;
			cols_q   <= cols_d;
			kmax_q   <= kmax_d;
			is_mul_q <= is_mul_d;
			is_sub_q <= is_sub_d;
		end
	end

	`MAS_CHECK_NOW(a_written_when_waiting, status.written, (state_q == S_DRAIN || state_q == S_ERR))
	`MAS_CHECK_NOW(a_k_in_range, (state_q == S_ISSUE), (DIM_W'(k_q) < kmax_q))
	`MAS_CHECK_NEXT(a_issue_then_drain, (state_q == S_ISSUE && last_k), (state_q == S_DRAIN))

endmodule

`default_nettype wire

@@ rtl/core/matrix_add_sub_multiply.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_add_sub_multiply_macros.svh"

// Matrix add, subtract and multiply on signed Q16.16 elements. Elements of
// matrices A and B are loaded one per transfer on the load channel, at one
// transfer per cycle while the block is idle. The transfer marked final_load
// is stored and then starts the operation held in the operation register;
// the result matrix leaves on the result channel in row-major order with
// is_last on its final element. Add and subtract saturate each element to
// the signed 32-bit range; multiply sums exact products in a wide
// accumulator, rounds half toward plus infinity and then saturates. When the
// configured dimensions do not fit the operation, a single transfer with
// dim_error and is_last set and a zero value is sent instead, and operation
// code 3 starts nothing. For each result element the output register is
// claimed once free, then K pairs of store entries (K is a_cols for multiply,
// 1 for add and subtract) are read at one pair per cycle through the single
// read port of each store into the multiply-accumulate unit and pass its
// read, multiply, accumulate and rounding stages; the next element waits
// until this one is in the output register. No loads are taken while a run
// is in progress. Configuration writes are always taken and must only be
// issued while the block is idle. Dimension writes keep their low four
// bits; zero is held as one and above eight as eight.
module matrix_add_sub_multiply (
	input  wire logic     clk,
	input  wire logic     arst_n,
	mas_load_if.sink      load,
	mas_result_if.source  result,
	mas_cfg_if.sink       cfg
);

	mas_pkg::mas_cfg_t    cfg_q;
	mas_pkg::mas_cmd_t    cmd;
	mas_pkg::mas_status_t status;

	logic load_ready;
	logic load_accept;
	logic cfg_write;

	// Configuration register bank.
	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.operation <= mas_pkg::OP_ADD;
			cfg_q.a_rows    <= mas_pkg::DIM_W'(1);
			cfg_q.a_cols    <= mas_pkg::DIM_W'(1);
			cfg_q.b_rows    <= mas_pkg::DIM_W'(1);
			cfg_q.b_cols    <= mas_pkg::DIM_W'(1);
		end else if (cfg_write) begin
			case (cfg.index)
				mas_pkg::REG_OPERATION: cfg_q.operation <= cfg.data[mas_pkg::OP_W-1:0];
				mas_pkg::REG_A_ROWS:    cfg_q.a_rows <= mas_pkg::clamp_dim(cfg.data);
				mas_pkg::REG_A_COLS:    cfg_q.a_cols <= mas_pkg::clamp_dim(cfg.data);
				mas_pkg::REG_B_ROWS:    cfg_q.b_rows <= mas_pkg::clamp_dim(cfg.data);
				mas_pkg::REG_B_COLS:    cfg_q.b_cols <= mas_pkg::clamp_dim(cfg.data);
				default:                cfg_q <= cfg_q;
			endcase
		end
	end

	// A load transfer writes the store in the cycle it is accepted.
	assign load.ready  = load_ready;
	assign load_accept = load.valid && load_ready;

	mas_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.load_accept (load_accept),
		.load_final  (load.final_load),
		.load_ready  (load_ready),
		.status      (status),
		.cmd         (cmd)
	);

	mas_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_wr      (load_accept),
		.load_target  (load.target),
		.load_row     (load.row_index),
		.load_col     (load.col_index),
		.load_element (load.element),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.out_row      (result.out_row),
		.out_col      (result.out_col),
		.out_value    (result.out_value),
		.out_last     (result.is_last),
		.out_err      (result.dim_error)
	);

	// Dimension registers always hold a usable size.
	`MAS_CHECK_NOW(a_dims_in_range, 1'b1, (cfg_q.a_rows != '0 && cfg_q.a_cols != '0 && cfg_q.b_rows != '0 && cfg_q.b_cols != '0))

endmodule

`default_nettype wire
